// File: sv/lnf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnf_pkg: shared types and constants for the layer normalization block
// Holds widths, command and register codes, and the structs that pass
// between the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package lnf_pkg;

    localparam int MAX_ROW = 64;
    localparam int DATA_W  = 16;
    localparam int ADDR_W  = $clog2(MAX_ROW);
    localparam int LEN_W   = $clog2(MAX_ROW + 1);
    localparam int INV_W   = 24;
    localparam int SUM_W   = DATA_W + ADDR_W + 1;
    localparam int SQ_W    = 2 * DATA_W + 2;
    localparam int SS_W    = 2 * DATA_W + ADDR_W + 1;
    localparam int DIVD_W  = 61;
    localparam int DIVS_W  = 55;
    localparam int ROOT_W  = 46;
    localparam int CFG_IDX_W = 1;

    localparam logic [DIVS_W-1:0] EPS_Q32 = DIVS_W'(42950);

    localparam logic CMD_TABLE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_APPLY_SHIFT = 1'b1;

    // One completed row waiting for the back end.
    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] len;
    } lnf_job_t;

    // One result entry in the output queue.
    typedef struct packed {
        logic [DATA_W-1:0] normalized;
        logic [DATA_W-1:0] mean;
        logic [INV_W-1:0]  inv;
        logic              last;
    } lnf_result_t;

endpackage

// File: sv/layer_norm_forward.sv
`timescale 1ns / 1ps
// Sequence: after the request that completes a row, the back end sums the samples,
// runs three divisions on the shared divider (mean, variance, inverse) and the
// 23-step square root, then streams results through the four-entry result queue.
// Requests stall while a row is in the back end; its results may still drain after.
// Reset (rst_n, asynchronous, active low) clears control, row_length 64, apply_shift 1.
// ----------------------------------------------------------------------------
// layer_norm_forward: fixed-point layer normalization of one row
// The front end takes table writes and row samples; the back end computes
// mean and inverse deviation and streams normalized results.
// ----------------------------------------------------------------------------
module layer_norm_forward (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request side.
    input  logic                              push,
    output logic                              full,
    input  logic                              command,
    input  logic [lnf_pkg::ADDR_W-1:0]        entry_index,
    input  logic signed [lnf_pkg::DATA_W-1:0] sample,
    input  logic signed [lnf_pkg::DATA_W-1:0] scale_value,
    input  logic signed [lnf_pkg::DATA_W-1:0] shift_value,
    input  logic                              end_of_row,
    // Result side.
    output logic                              empty,
    input  logic                              pop,
    output logic signed [lnf_pkg::DATA_W-1:0] normalized,
    output logic signed [lnf_pkg::DATA_W-1:0] row_mean,
    output logic [lnf_pkg::INV_W-1:0]         inv_std,
    output logic                              last_of_row,
    // Configuration writes.
    input  logic                              cfg_write,
    input  logic [lnf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lnf_pkg::LEN_W-1:0]         cfg_data
);
    import lnf_pkg::*;

    logic [LEN_W-1:0]  row_length_reg;
    logic              apply_shift_reg;

    lnf_job_t          job;
    logic              job_take;
    logic              back_idle;
    logic              row_we;
    logic [ADDR_W-1:0] row_waddr;
    logic [DATA_W-1:0] row_wdata;
    logic              tab_we;
    logic [ADDR_W-1:0] tab_waddr;
    logic [DATA_W-1:0] scale_wdata;
    logic [DATA_W-1:0] shift_wdata;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] row_rdata;
    logic [DATA_W-1:0] scale_rdata;
    logic [DATA_W-1:0] shift_rdata;
    lnf_result_t       result;

    // Configuration registers. The user must write them only while the block is idle;
    // the block does not enforce this, and the front and back ends read them directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg  <= LEN_W'(MAX_ROW);
            apply_shift_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ROW_LENGTH:  row_length_reg  <= cfg_data;
                REG_APPLY_SHIFT: apply_shift_reg <= cfg_data[0];
                default:         row_length_reg  <= row_length_reg;
            endcase
        end
    end

    // The front end stalls every request while a completed row is queued or
    // being processed, so the stored row and the tables stay stable while the
    // back end walks them.
    lnf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .command    (command),
        .entry_index(entry_index),
        .sample     (sample),
        .scale_value(scale_value),
        .shift_value(shift_value),
        .end_of_row (end_of_row),
        .row_length (row_length_reg),
        .back_idle  (back_idle),
        .job_take   (job_take),
        .full       (full),
        .job        (job),
        .row_we     (row_we),
        .row_waddr  (row_waddr),
        .row_wdata  (row_wdata),
        .tab_we     (tab_we),
        .tab_waddr  (tab_waddr),
        .scale_wdata(scale_wdata),
        .shift_wdata(shift_wdata)
    );

    lnf_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROW)) u_row_store (
        .clk  (clk),
        .we   (row_we),
        .waddr(row_waddr),
        .wdata(row_wdata),
        .raddr(rd_addr),
        .rdata(row_rdata)
    );

    lnf_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROW)) u_scale_table (
        .clk  (clk),
        .we   (tab_we),
        .waddr(tab_waddr),
        .wdata(scale_wdata),
        .raddr(rd_addr),
        .rdata(scale_rdata)
    );

    lnf_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROW)) u_shift_table (
        .clk  (clk),
        .we   (tab_we),
        .waddr(tab_waddr),
        .wdata(shift_wdata),
        .raddr(rd_addr),
        .rdata(shift_rdata)
    );

    // The back end owns the result queue; each entry carries its own mean and
    // inverse deviation so a new row may start while old results drain.
    lnf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (job),
        .apply_shift(apply_shift_reg),
        .job_take   (job_take),
        .idle       (back_idle),
        .rd_addr    (rd_addr),
        .row_rdata  (row_rdata),
        .scale_rdata(scale_rdata),
        .shift_rdata(shift_rdata),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

    assign normalized  = result.normalized;
    assign row_mean    = result.mean;
    assign inv_std     = result.inv;
    assign last_of_row = result.last;

    // A row marked complete must block the next request.
    a_row_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && command == CMD_SAMPLE && end_of_row) |=> full)
        else $error("request accepted right after a row was completed");

    // A queued row always has at least one sample.
    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        job.valid |-> (job.len != '0))
        else $error("queued row has no samples");

    // The back end only leaves idle by taking a queued row.
    a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |=> (!back_idle && !job.valid))
        else $error("row taken but back end did not start");

endmodule

// File: sv/lnf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnf_ram: generic single write, single read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lnf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/lnf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnf_div: sequential unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lnf_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [lnf_pkg::DIVD_W-1:0] dividend,
    input  logic [lnf_pkg::DIVS_W-1:0] divisor,
    output logic                      done,
    output logic [lnf_pkg::DIVD_W-1:0] quotient,
    output logic [lnf_pkg::DIVS_W-1:0] remainder
);
    import lnf_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W);

    logic [DIVS_W-1:0] rem_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIVS_W:0]   trial;
    logic              ge;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVD_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DIVS_W'(trial - {1'b0, dvs_reg}) : trial[DIVS_W-1:0];
            quo_reg <= {quo_reg[DIVD_W-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: sv/lnf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnf_front: request intake and row assembly
// Writes table entries and row samples and hands completed rows to the
// back end through a one-entry job queue.
// ----------------------------------------------------------------------------
module lnf_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic                        command,
    input  logic [lnf_pkg::ADDR_W-1:0]  entry_index,
    input  logic [lnf_pkg::DATA_W-1:0]  sample,
    input  logic [lnf_pkg::DATA_W-1:0]  scale_value,
    input  logic [lnf_pkg::DATA_W-1:0]  shift_value,
    input  logic                        end_of_row,
    input  logic [lnf_pkg::LEN_W-1:0]   row_length,
    input  logic                        back_idle,
    input  logic                        job_take,
    output logic                        full,
    output lnf_pkg::lnf_job_t           job,
    output logic                        row_we,
    output logic [lnf_pkg::ADDR_W-1:0]  row_waddr,
    output logic [lnf_pkg::DATA_W-1:0]  row_wdata,
    output logic                        tab_we,
    output logic [lnf_pkg::ADDR_W-1:0]  tab_waddr,
    output logic [lnf_pkg::DATA_W-1:0]  scale_wdata,
    output logic [lnf_pkg::DATA_W-1:0]  shift_wdata
);
    import lnf_pkg::*;

    logic [LEN_W-1:0] count_reg;
    logic [LEN_W-1:0] count_next;
    logic [LEN_W-1:0] lim;
    lnf_job_t         job_reg;
    logic             accept;
    logic             row_done;

    // A row length of zero acts as one; anything past the store depth is capped.
    always_comb
    begin
        if (row_length == '0)
        begin
            lim = LEN_W'(1);
        end
        else if (row_length > LEN_W'(MAX_ROW))
        begin
            lim = LEN_W'(MAX_ROW);
        end
        else
        begin
            lim = row_length;
        end
    end

    assign full       = job_reg.valid | ~back_idle;
    assign accept     = push & ~full;
    assign count_next = count_reg + 1'b1;
    assign row_done   = end_of_row | (count_next >= lim);

    assign row_we      = accept & (command == CMD_SAMPLE);
    assign row_waddr   = count_reg[ADDR_W-1:0];
    assign row_wdata   = sample;
    assign tab_we      = accept & (command == CMD_TABLE);
    assign tab_waddr   = entry_index;
    assign scale_wdata = scale_value;
    assign shift_wdata = shift_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            job_reg.valid <= 1'b0;
            job_reg.len   <= '0;
        end
        else
        begin
            if (job_take)
            begin
                job_reg.valid <= 1'b0;
            end
            if (row_we)
            begin
                if (row_done)
                begin
                    count_reg     <= '0;
                    job_reg.valid <= 1'b1;
                    job_reg.len   <= count_next;
                end
                else
                begin
                    count_reg <= count_next;
                end
            end
        end
    end

    assign job = job_reg;

endmodule

// File: sv/lnf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnf_back: row statistics and output pipeline
// Walks the stored row for the mean and the variance, runs the divider and
// the bit-serial square root, then streams results into an output queue.
// ----------------------------------------------------------------------------
module lnf_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lnf_pkg::lnf_job_t          job,
    input  logic                       apply_shift,
    output logic                       job_take,
    output logic                       idle,
    output logic [lnf_pkg::ADDR_W-1:0] rd_addr,
    input  logic [lnf_pkg::DATA_W-1:0] row_rdata,
    input  logic [lnf_pkg::DATA_W-1:0] scale_rdata,
    input  logic [lnf_pkg::DATA_W-1:0] shift_rdata,
    input  logic                       pop,
    output logic                       empty,
    output lnf_pkg::lnf_result_t       result
);
    import lnf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SUM, S_MDIV, S_VAR, S_VDIV, S_IDIV, S_SQRT, S_OUT
    } state_t;

    localparam int QD = 4;
    localparam int QP_W = $clog2(QD);
    localparam int QC_W = $clog2(QD + 1);

    state_t                   state_reg;
    logic [LEN_W-1:0]         n_reg;
    logic [LEN_W-1:0]         idx_reg;
    logic                     rvld_reg;
    logic                     last0_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     neg_reg;
    logic signed [DATA_W-1:0] mean_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic                     sqvld_reg;
    logic [SS_W-1:0]          ss_reg;
    logic [ROOT_W-1:0]        v_reg;
    logic [ROOT_W-1:0]        r_reg;
    logic [ROOT_W-1:0]        bit_reg;
    logic [INV_W-1:0]         inv_reg;
    logic                     start_reg;
    logic [DIVD_W-1:0]        dvd_reg;
    logic [DIVS_W-1:0]        dvs_reg;

    logic                     div_done;
    logic [DIVD_W-1:0]        div_q;
    logic [DIVS_W-1:0]        div_r;

    logic signed [DATA_W:0]   d;
    logic [DATA_W:0]          dmag;
    logic signed [SUM_W+1:0]  mean_num;
    logic [DATA_W:0]          mean_q;
    logic [DIVS_W-1:0]        den;
    logic [ROOT_W-1:0]        trial;

    // Output pipeline.
    logic signed [2*DATA_W:0]         ds_reg;
    logic signed [DATA_W-1:0]         sh1_reg;
    logic                             v1_reg;
    logic                             last1_reg;
    logic signed [2*DATA_W+INV_W+1:0] p_reg;
    logic signed [DATA_W-1:0]         sh2_reg;
    logic                             v2_reg;
    logic                             last2_reg;
    logic signed [2*DATA_W+INV_W+1:0] p_rnd;
    logic signed [2*DATA_W+INV_W-21:0] y0;
    logic signed [2*DATA_W+INV_W-20:0] y1;
    logic signed [DATA_W-1:0]         y;

    // Output queue.
    lnf_result_t     q_mem [QD];
    logic [QP_W-1:0] wp_reg;
    logic [QP_W-1:0] rp_reg;
    logic [QC_W-1:0] qcnt_reg;
    logic [QC_W:0]   inflight;
    logic            q_pop;
    logic            issue_ok;
    lnf_result_t     q_in;

    lnf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .done     (div_done),
        .quotient (div_q),
        .remainder(div_r)
    );

    assign rd_addr  = idx_reg[ADDR_W-1:0];
    assign idle     = (state_reg == S_IDLE);
    assign job_take = idle & job.valid;

    assign d        = $signed({row_rdata[DATA_W-1], row_rdata}) -
                      $signed({mean_reg[DATA_W-1], mean_reg});
    assign dmag     = d[DATA_W] ? DATA_W'(1) + ~d : d;
    assign mean_num = $signed({sum_reg, 1'b0}) + $signed({1'b0, SUM_W'(n_reg)});
    assign mean_q   = div_q[DATA_W:0] + (DATA_W+1)'(div_r != '0);
    assign den      = div_q[DIVS_W-1:0] + EPS_Q32;
    assign trial    = r_reg + bit_reg;

    assign inflight = (QC_W+1)'(rvld_reg) + (QC_W+1)'(v1_reg) + (QC_W+1)'(v2_reg);
    assign issue_ok = ((QC_W+1)'(qcnt_reg) + inflight) < (QC_W+1)'(QD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rvld_reg  <= 1'b0;
            sqvld_reg <= 1'b0;
            start_reg <= 1'b0;
            idx_reg   <= '0;
            n_reg     <= '0;
        end
        else
        begin
            start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    rvld_reg <= 1'b0;
                    if (job.valid)
                    begin
                        n_reg     <= job.len;
                        idx_reg   <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    rvld_reg <= (idx_reg != n_reg);
                    if (idx_reg != n_reg)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (rvld_reg)
                    begin
                        sum_reg <= sum_reg + SUM_W'($signed(row_rdata));
                    end
                    else if (idx_reg == n_reg)
                    begin
                        // Mean rounds half up: floor((2*sum + n) / (2*n)).
                        neg_reg   <= mean_num[SUM_W+1];
                        dvd_reg   <= DIVD_W'(mean_num[SUM_W+1] ? -mean_num : mean_num);
                        dvs_reg   <= DIVS_W'({n_reg, 1'b0});
                        start_reg <= 1'b1;
                        state_reg <= S_MDIV;
                    end
                end
                S_MDIV:
                begin
                    if (div_done)
                    begin
                        mean_reg  <= neg_reg ? DATA_W'(-mean_q) : div_q[DATA_W-1:0];
                        idx_reg   <= '0;
                        ss_reg    <= '0;
                        state_reg <= S_VAR;
                    end
                end
                S_VAR:
                begin
                    rvld_reg  <= (idx_reg != n_reg);
                    sqvld_reg <= rvld_reg;
                    if (idx_reg != n_reg)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (rvld_reg)
                    begin
                        sq_reg <= dmag * dmag;
                    end
                    if (sqvld_reg)
                    begin
                        ss_reg <= ss_reg + SS_W'(sq_reg);
                    end
                    else if (idx_reg == n_reg && !rvld_reg)
                    begin
                        dvd_reg   <= DIVD_W'({ss_reg, 16'h0000});
                        dvs_reg   <= DIVS_W'(n_reg);
                        start_reg <= 1'b1;
                        state_reg <= S_VDIV;
                    end
                end
                S_VDIV:
                begin
                    if (div_done)
                    begin
                        dvd_reg   <= DIVD_W'(1) << 60;
                        dvs_reg   <= den;
                        start_reg <= 1'b1;
                        state_reg <= S_IDIV;
                    end
                end
                S_IDIV:
                begin
                    if (div_done)
                    begin
                        v_reg     <= div_q[ROOT_W-1:0];
                        r_reg     <= '0;
                        bit_reg   <= ROOT_W'(1) << (ROOT_W - 2);
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (bit_reg == '0)
                    begin
                        inv_reg   <= r_reg[INV_W-1:0];
                        idx_reg   <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        if (v_reg >= trial)
                        begin
                            v_reg <= v_reg - trial;
                            r_reg <= (r_reg >> 1) + bit_reg;
                        end
                        else
                        begin
                            r_reg <= r_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                end
                S_OUT:
                begin
                    rvld_reg <= (idx_reg != n_reg) && issue_ok;
                    if (idx_reg != n_reg && issue_ok)
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        last0_reg <= (idx_reg + 1'b1 == n_reg);
                    end
                    else if (idx_reg == n_reg && !rvld_reg && !v1_reg && !v2_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Scale stage, then inverse-deviation stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= rvld_reg && (state_reg == S_OUT);
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ds_reg    <= d * $signed(scale_rdata);
        sh1_reg   <= $signed(shift_rdata);
        last1_reg <= last0_reg;
        p_reg     <= ds_reg * $signed({1'b0, inv_reg});
        sh2_reg   <= sh1_reg;
        last2_reg <= last1_reg;
    end

    // Round at bit 22, add the shift when apply_shift is set, saturate.
    always_comb
    begin
        p_rnd = p_reg + (($bits(p_reg))'(1) <<< 21);
        y0    = p_rnd[$bits(p_reg)-1:22];
        y1    = $signed({y0[$bits(y0)-1], y0}) +
                (apply_shift ? ($bits(y1))'(sh2_reg) : ($bits(y1))'(0));
        if (y1 > ($bits(y1))'(32767))
        begin
            y = 16'sh7FFF;
        end
        else if (y1 < -($bits(y1))'(32768))
        begin
            y = -16'sh8000;
        end
        else
        begin
            y = y1[DATA_W-1:0];
        end
        q_in.normalized = y;
        q_in.mean       = mean_reg;
        q_in.inv        = inv_reg;
        q_in.last       = last2_reg;
    end

    assign q_pop  = pop & (qcnt_reg != '0);
    assign empty  = (qcnt_reg == '0);
    assign result = q_mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            qcnt_reg <= '0;
        end
        else
        begin
            if (v2_reg)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (q_pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            qcnt_reg <= qcnt_reg + QC_W'(v2_reg) - QC_W'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            q_mem[wp_reg] <= q_in;
        end
    end

endmodule
